@@ rtl/core/srw_pkg.sv @@
// Shared constants and request type for the selective-repeat window tracker.
package srw_pkg;

  localparam int unsigned WINDOW      = 8;
  localparam int unsigned SEQ_SPACE   = 16;
  localparam int unsigned SLOTS       = 256;
  localparam int unsigned PAYLOAD_MAX = 1024;

  localparam int unsigned SEQ_W   = 4;
  localparam int unsigned PLEN_W  = 11;
  localparam int unsigned SLOT_W  = 8;
  localparam int unsigned BASE_W  = 9;
  localparam int unsigned BYTES_W = 19;
  localparam int unsigned WIN_W   = $clog2(WINDOW);

  localparam logic [BYTES_W-1:0] BYTES_SAT = {BYTES_W{1'b1}};

  typedef enum logic [1:0] {
    OP_CLEAR = 2'd0,
    OP_DATA  = 2'd1,
    OP_ACK   = 2'd2
  } op_t;

  typedef struct packed {
    op_t               op;
    logic              last;
    logic [SEQ_W-1:0]  seq;
    logic [PLEN_W-1:0] plen;
  } req_t;

endpackage

@@ rtl/core/selective_repeat_window_tracker.sv @@
// Top level of the selective-repeat window tracker: intake, request queue, window update.
//
//   channel   direction  handshake             fields
//   request   in         start && !busy        kind, is_ack, is_last, seqno, payload_length
//   result    out        strobe (one cycle)    accepted .. overflow
//
// A request is executed and then the base advances over the marked slots at the window start;
// the base advance steps one slot per cycle in the window update stage. A clear skips it.
// Reset (rst, synchronous) empties the queue and clears the window, bitmap and byte total.
// Up to four requests may be in flight (intake register, two queue entries and the one in
// window update); busy rises only when the intake register and both queue entries are
// taken. Results cannot be held off by the receiver.
module selective_repeat_window_tracker import srw_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic               kind,
  input  logic               is_ack,
  input  logic               is_last,
  input  logic [SEQ_W-1:0]   seqno,
  input  logic [PLEN_W-1:0]  payload_length,
  output logic               strobe,
  output logic               accepted,
  output logic               duplicate_reack,
  output logic               send_ack,
  output logic [SEQ_W-1:0]   ack_seqno,
  output logic               ack_last,
  output logic [SLOT_W-1:0]  slot_index,
  output logic [BASE_W-1:0]  window_base,
  output logic               done_res,
  output logic [BYTES_W-1:0] bytes_total,
  output logic               overflow
);

  logic push;
  req_t push_req;
  logic q_full;
  logic q_empty;
  logic pop;
  req_t head;

  srw_front u_front (
    .clk            (clk),
    .rst            (rst),
    .start          (start),
    .kind           (kind),
    .is_ack         (is_ack),
    .is_last        (is_last),
    .seqno          (seqno),
    .payload_length (payload_length),
    .q_full         (q_full),
    .busy           (busy),
    .push           (push),
    .push_req       (push_req)
  );

  srw_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_req (push_req),
    .pop      (pop),
    .head     (head),
    .full     (q_full),
    .empty    (q_empty)
  );

  srw_back u_back (
    .clk             (clk),
    .rst             (rst),
    .q_empty         (q_empty),
    .head            (head),
    .pop             (pop),
    .strobe          (strobe),
    .accepted        (accepted),
    .duplicate_reack (duplicate_reack),
    .send_ack        (send_ack),
    .ack_seqno       (ack_seqno),
    .ack_last        (ack_last),
    .slot_index      (slot_index),
    .window_base     (window_base),
    .done_res        (done_res),
    .bytes_total     (bytes_total),
    .overflow        (overflow)
  );

endmodule

@@ rtl/core/srw_front.sv @@
// Request intake: decodes a segment header or clear and hands it to the queue.
module srw_front import srw_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic              kind,
  input  logic              is_ack,
  input  logic              is_last,
  input  logic [SEQ_W-1:0]  seqno,
  input  logic [PLEN_W-1:0] payload_length,
  input  logic              q_full,
  output logic              busy,
  output logic              push,
  output req_t              push_req
);

  logic hold_valid;
  req_t hold;
  req_t decoded;
  logic take;

  always_comb begin
    decoded.op   = !kind ? OP_CLEAR : (is_ack ? OP_ACK : OP_DATA);
    decoded.last = is_last;
    decoded.seq  = seqno;
    decoded.plen = (payload_length > PLEN_W'(PAYLOAD_MAX)) ? PLEN_W'(PAYLOAD_MAX)
                                                           : payload_length;
  end

  assign busy     = hold_valid && q_full;
  assign take     = start && !busy;
  assign push     = hold_valid && !q_full;
  assign push_req = hold;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (take) begin
      hold_valid <= 1'b1;
    end else if (push) begin
      hold_valid <= 1'b0;
    end
    if (take) begin
      hold <= decoded;
    end
  end

endmodule

@@ rtl/core/srw_queue.sv @@
// Two-entry request queue between intake and window update.
module srw_queue import srw_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  req_t push_req,
  input  logic pop,
  output req_t head,
  output logic full,
  output logic empty
);

  req_t       entry [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign full  = (count == 2'd2);
  assign empty = (count == 2'd0);
  assign head  = entry[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
    if (push) begin
      entry[wr_ptr] <= push_req;
    end
  end

endmodule

@@ rtl/core/srw_back.sv @@
// Window update: marks slots, counts bytes, advances the base and issues results.
module srw_back import srw_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               q_empty,
  input  req_t               head,
  output logic               pop,
  output logic               strobe,
  output logic               accepted,
  output logic               duplicate_reack,
  output logic               send_ack,
  output logic [SEQ_W-1:0]   ack_seqno,
  output logic               ack_last,
  output logic [SLOT_W-1:0]  slot_index,
  output logic [BASE_W-1:0]  window_base,
  output logic               done_res,
  output logic [BYTES_W-1:0] bytes_total,
  output logic               overflow
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_ADV
  } state_t;

  state_t             state;
  req_t               cur;
  logic [BASE_W-1:0]  base;
  logic [WINDOW-1:0]  win_mark;
  logic [WINDOW-1:0]  win_last;
  logic [WINDOW-1:0]  hist_last;
  logic [BYTES_W-1:0] byte_count;
  logic               finished;

  logic [SEQ_W-1:0]   seq_dist;
  logic               in_win;
  logic [WIN_W-1:0]   widx;
  logic [BASE_W:0]    slot_sum;
  logic               beyond;
  logic               in_prev;
  logic [SEQ_W:0]     back_amt;
  logic [WIN_W-1:0]   hidx;
  logic               back_ok;
  logic [BASE_W-1:0]  prev_slot;
  logic [BYTES_W:0]   byte_sum;
  logic [BYTES_W-1:0] byte_next;
  logic               is_data;
  logic               fin_next;

  assign pop = (state == S_IDLE) && !q_empty;

  always_comb begin
    is_data   = (cur.op == OP_DATA);
    seq_dist  = cur.seq - base[SEQ_W-1:0];
    in_win    = seq_dist < SEQ_W'(WINDOW);
    widx      = seq_dist[WIN_W-1:0];
    slot_sum  = {1'b0, base} + (BASE_W+1)'(seq_dist);
    beyond    = slot_sum >= (BASE_W+1)'(SLOTS);
    in_prev   = !in_win && is_data &&
                (({1'b0, seq_dist} + (SEQ_W+1)'(WINDOW)) >= (SEQ_W+1)'(SEQ_SPACE));
    back_amt  = (SEQ_W+1)'(SEQ_SPACE) - {1'b0, seq_dist};
    hidx      = WIN_W'(back_amt - (SEQ_W+1)'(1));
    back_ok   = base >= BASE_W'(back_amt);
    prev_slot = base - BASE_W'(back_amt);
    byte_sum  = {1'b0, byte_count} + (BYTES_W+1)'(cur.plen);
    byte_next = (byte_sum > {1'b0, BYTES_SAT}) ? BYTES_SAT : byte_sum[BYTES_W-1:0];
    fin_next  = finished || ((base != '0) && hist_last[0]);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      base       <= '0;
      win_mark   <= '0;
      win_last   <= '0;
      hist_last  <= '0;
      byte_count <= '0;
      finished   <= 1'b0;
      strobe     <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          strobe <= 1'b0;
          if (pop) begin
            cur   <= head;
            state <= S_EXEC;
          end
        end
        S_EXEC: begin
          accepted        <= 1'b0;
          duplicate_reack <= 1'b0;
          send_ack        <= 1'b0;
          ack_seqno       <= '0;
          ack_last        <= 1'b0;
          slot_index      <= '0;
          overflow        <= 1'b0;
          if (cur.op == OP_CLEAR) begin
            base        <= '0;
            win_mark    <= '0;
            win_last    <= '0;
            hist_last   <= '0;
            byte_count  <= '0;
            finished    <= 1'b0;
            window_base <= '0;
            done_res    <= 1'b0;
            bytes_total <= '0;
            strobe      <= 1'b1;
            state       <= S_IDLE;
          end else begin
            strobe <= 1'b0;
            if (in_win) begin
              if (beyond) begin
                overflow <= 1'b1;
              end else begin
                if (is_data && !win_mark[widx]) begin
                  byte_count <= byte_next;
                end
                win_mark[widx] <= 1'b1;
                win_last[widx] <= win_last[widx] | cur.last;
                accepted       <= 1'b1;
                slot_index     <= slot_sum[SLOT_W-1:0];
                if (is_data) begin
                  send_ack  <= 1'b1;
                  ack_seqno <= cur.seq;
                  ack_last  <= win_last[widx] | cur.last;
                end
              end
            end else if (in_prev && back_ok) begin
              duplicate_reack <= 1'b1;
              send_ack        <= 1'b1;
              ack_seqno       <= cur.seq;
              ack_last        <= hist_last[hidx];
              slot_index      <= prev_slot[SLOT_W-1:0];
            end
            state <= S_ADV;
          end
        end
        S_ADV: begin
          if ((base < BASE_W'(SLOTS)) && win_mark[0]) begin
            hist_last <= {hist_last[WINDOW-2:0], win_last[0]};
            win_mark  <= {1'b0, win_mark[WINDOW-1:1]};
            win_last  <= {1'b0, win_last[WINDOW-1:1]};
            base      <= base + BASE_W'(1);
            strobe    <= 1'b0;
          end else begin
            finished    <= fin_next;
            done_res    <= fin_next;
            window_base <= base;
            bytes_total <= byte_count;
            strobe      <= 1'b1;
            state       <= S_IDLE;
          end
        end
        default: begin
          strobe <= 1'b0;
          state  <= S_IDLE;
        end
      endcase
    end
  end

endmodule

@@ verif/tb_selective_repeat_window_tracker.sv @@
// Self-checking testbench for the selective-repeat window tracker: directed and random requests.
module tb_selective_repeat_window_tracker;
  timeunit 1ns;
  timeprecision 1ps;
  import srw_pkg::*;

  typedef struct packed {
    logic              kind;
    logic              ack;
    logic              last;
    logic [SEQ_W-1:0]  seq;
    logic [PLEN_W-1:0] plen;
  } seg_req_t;

  typedef struct packed {
    logic               accepted;
    logic               duplicate_reack;
    logic               send_ack;
    logic [SEQ_W-1:0]   ack_seqno;
    logic               ack_last;
    logic [SLOT_W-1:0]  slot_index;
    logic [BASE_W-1:0]  window_base;
    logic               done_res;
    logic [BYTES_W-1:0] bytes_total;
    logic               overflow;
  } seg_result_t;

  typedef struct packed {
    logic        typed;
    seg_result_t want;
  } pending_t;

  typedef struct packed {
    seg_req_t    req;
    logic        typed;
    seg_result_t want;
  } dir_row_t;

  localparam int unsigned BYTE_LIMIT = 524287;
  localparam int unsigned PHASES = 3;
  localparam int unsigned PHASE_ITEMS = 390;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               start = 1'b0;
  logic               busy;
  logic               kind = 1'b0;
  logic               is_ack = 1'b0;
  logic               is_last = 1'b0;
  logic [SEQ_W-1:0]   seqno = '0;
  logic [PLEN_W-1:0]  payload_length = '0;
  logic               strobe;
  logic               accepted;
  logic               duplicate_reack;
  logic               send_ack;
  logic [SEQ_W-1:0]   ack_seqno;
  logic               ack_last;
  logic [SLOT_W-1:0]  slot_index;
  logic [BASE_W-1:0]  window_base;
  logic               done_res;
  logic [BYTES_W-1:0] bytes_total;
  logic               overflow;

  bit          slot_seen [SLOTS];
  bit          slot_end [SLOTS];
  int unsigned base_pos = 0;
  int unsigned byte_sum = 0;
  bit          xfer_done = 1'b0;
  int unsigned base_hint = 0;

  seg_result_t exp_q [$];
  pending_t    pend_q [$];
  int unsigned n_sent = 0;
  int unsigned n_checked = 0;
  int unsigned n_fail = 0;
  int unsigned n_acc = 0;
  int unsigned n_reack = 0;
  int unsigned n_ovf = 0;
  int unsigned n_clear = 0;
  int unsigned n_done = 0;

  selective_repeat_window_tracker dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .kind(kind), .is_ack(is_ack), .is_last(is_last), .seqno(seqno),
    .payload_length(payload_length), .strobe(strobe), .accepted(accepted),
    .duplicate_reack(duplicate_reack), .send_ack(send_ack), .ack_seqno(ack_seqno),
    .ack_last(ack_last), .slot_index(slot_index), .window_base(window_base),
    .done_res(done_res), .bytes_total(bytes_total), .overflow(overflow)
  );

  always #5 clk = ~clk;

  function automatic seg_result_t track_segment(input logic k, input logic a, input logic l,
                                                input logic [SEQ_W-1:0] s,
                                                input logic [PLEN_W-1:0] plen);
    seg_result_t r;
    int unsigned d;
    int unsigned slot;
    int unsigned back;
    int unsigned p;
    r = '0;
    if (!k) begin
      slot_seen = '{default: 1'b0};
      slot_end = '{default: 1'b0};
      base_pos = 0;
      byte_sum = 0;
      xfer_done = 1'b0;
    end else begin
      d = (int'(s) + SEQ_SPACE - (base_pos % SEQ_SPACE)) % SEQ_SPACE;
      if (d < WINDOW) begin
        slot = base_pos + d;
        if (slot >= SLOTS) begin
          r.overflow = 1'b1;
        end else begin
          if (!a && !slot_seen[slot]) begin
            p = (plen > PAYLOAD_MAX) ? PAYLOAD_MAX : int'(plen);
            byte_sum = byte_sum + p;
            if (byte_sum > BYTE_LIMIT) byte_sum = BYTE_LIMIT;
          end
          slot_seen[slot] = 1'b1;
          slot_end[slot] = slot_end[slot] | l;
          r.accepted = 1'b1;
          r.slot_index = SLOT_W'(slot);
          if (!a) begin
            r.send_ack = 1'b1;
            r.ack_seqno = s;
            r.ack_last = slot_end[slot];
          end
          while (base_pos < SLOTS && slot_seen[base_pos]) base_pos++;
        end
      end else if (!a && d + WINDOW >= SEQ_SPACE) begin
        back = SEQ_SPACE - d;
        if (base_pos >= back) begin
          slot = base_pos - back;
          r.duplicate_reack = 1'b1;
          r.send_ack = 1'b1;
          r.ack_seqno = s;
          r.ack_last = slot_end[slot];
          r.slot_index = SLOT_W'(slot);
        end
      end
      if (base_pos > 0 && slot_end[base_pos-1]) xfer_done = 1'b1;
    end
    r.window_base = BASE_W'(base_pos);
    r.done_res = xfer_done;
    r.bytes_total = BYTES_W'(byte_sum);
    return r;
  endfunction

  function automatic void check_field(input string name, input int unsigned want,
                                      input int unsigned got);
    if (want != got) begin
      n_fail++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    end
  endfunction

  function automatic void compare_result(input seg_result_t want, input seg_result_t got);
    check_field("accepted", want.accepted, got.accepted);
    check_field("duplicate_reack", want.duplicate_reack, got.duplicate_reack);
    check_field("send_ack", want.send_ack, got.send_ack);
    check_field("ack_seqno", want.ack_seqno, got.ack_seqno);
    check_field("ack_last", want.ack_last, got.ack_last);
    check_field("slot_index", want.slot_index, got.slot_index);
    check_field("window_base", want.window_base, got.window_base);
    check_field("done_res", want.done_res, got.done_res);
    check_field("bytes_total", want.bytes_total, got.bytes_total);
    check_field("overflow", want.overflow, got.overflow);
  endfunction

  function automatic seg_req_t seg(input logic k, input logic a, input logic l,
                                   input int unsigned s, input int unsigned p);
    return '{k, a, l, SEQ_W'(s), PLEN_W'(p)};
  endfunction

  function automatic seg_result_t res(input logic acc, input logic rea, input logic snd,
                                      input int unsigned aseq, input logic alast,
                                      input int unsigned slot, input int unsigned base,
                                      input logic dn, input int unsigned bytes,
                                      input logic ovf);
    return '{acc, rea, snd, SEQ_W'(aseq), alast, SLOT_W'(slot), BASE_W'(base), dn,
             BYTES_W'(bytes), ovf};
  endfunction

  function automatic seg_req_t next_segment(output bit counts);
    seg_req_t r;
    int unsigned pick;
    int unsigned b;
    int unsigned off;
    b = base_hint;
    pick = $urandom_range(999);
    counts = 1'b1;
    r.kind = 1'b1;
    r.ack = 1'b0;
    r.last = ($urandom_range(99) < 3);
    r.plen = PLEN_W'($urandom_range(0, 2047));
    r.seq = SEQ_W'($urandom);
    if (pick < 2 || (b == SLOTS && pick < 100)) begin
      r.kind = 1'b0;
      r.ack = 1'($urandom_range(1));
    end else if (pick < 600) begin
      off = ($urandom_range(3) == 0) ? $urandom_range(WINDOW - 1) : $urandom_range(2);
      r.seq = SEQ_W'(b + off);
    end else if (pick < 750) begin
      r.ack = 1'b1;
      r.seq = SEQ_W'(b + $urandom_range(WINDOW - 1));
    end else if (pick < 870) begin
      r.seq = SEQ_W'(b + SEQ_SPACE - $urandom_range(1, WINDOW));
    end else begin
      r.kind = ($urandom_range(9) != 0);
      r.ack = 1'($urandom_range(1));
      r.last = 1'($urandom_range(1));
      counts = 1'b0;
    end
    return r;
  endfunction

  task automatic send_segment(input seg_req_t r, input logic typed, input seg_result_t want);
    pend_q.push_back('{typed, want});
    n_sent++;
    start <= 1'b1;
    kind <= r.kind;
    is_ack <= r.ack;
    is_last <= r.last;
    seqno <= r.seq;
    payload_length <= r.plen;
    do @(posedge clk); while (busy);
  endtask

  task automatic hold_sender(input int unsigned pct);
    if ($urandom_range(99) < pct) begin
      start <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < pct);
    end
  endtask

  task automatic drain_results();
    start <= 1'b0;
    while (n_checked != n_sent) @(negedge clk);
    @(posedge clk);
  endtask

  always @(negedge clk) base_hint <= base_pos;

  always @(posedge clk) begin
    seg_result_t got;
    seg_result_t want;
    seg_result_t model;
    pending_t p;
    if (!rst) begin
      if (strobe) begin
        got = '{accepted, duplicate_reack, send_ack, ack_seqno, ack_last, slot_index,
                window_base, done_res, bytes_total, overflow};
        if (exp_q.size() == 0) begin
          n_fail++;
          $display("%0t: unexpected result, expected none, actual %p", $time, got);
        end else begin
          want = exp_q.pop_front();
          compare_result(want, got);
          n_checked++;
        end
      end
      if (start && !busy) begin
        model = track_segment(kind, is_ack, is_last, seqno, payload_length);
        p = pend_q.pop_front();
        want = p.typed ? p.want : model;
        exp_q.push_back(want);
        n_acc += want.accepted;
        n_reack += want.duplicate_reack;
        n_ovf += want.overflow;
        n_done += want.done_res;
        n_clear += !kind;
      end
    end
  end

  initial begin
    #5_000_000;
    $display("tb_selective_repeat_window_tracker NOT OK");
    $finish;
  end

  initial begin
    dir_row_t    rows [$];
    int unsigned idle_pct [PHASES];
    int unsigned done_items;
    seg_req_t    r;
    bit          counts;
    idle_pct = '{0, 59, 6};
    rows = '{
      '{seg(1, 0, 0, 0, 0), 1'b1, res(1, 0, 1, 0, 0, 0, 1, 0, 0, 0)},
      '{seg(1, 0, 0, 1, 2047), 1'b1, res(1, 0, 1, 1, 0, 1, 2, 0, 1024, 0)},
      '{seg(1, 0, 0, 1, 5), 1'b0, '0},
      '{seg(1, 1, 0, 2, 77), 1'b0, '0},
      '{seg(1, 1, 0, 1, 0), 1'b0, '0},
      '{seg(1, 0, 1, 10, 1024), 1'b0, '0},
      '{seg(1, 0, 0, 11, 7), 1'b0, '0},
      '{seg(1, 0, 0, 15, 3), 1'b0, '0},
      '{seg(1, 0, 0, 3, 1), 1'b0, '0},
      '{seg(1, 0, 0, 4, 100), 1'b0, '0},
      '{seg(1, 0, 0, 5, 512), 1'b0, '0},
      '{seg(1, 1, 0, 6, 1000), 1'b0, '0},
      '{seg(1, 0, 0, 7, 1023), 1'b0, '0},
      '{seg(1, 0, 0, 8, 1025), 1'b0, '0},
      '{seg(1, 0, 0, 9, 64), 1'b0, '0},
      '{seg(1, 0, 0, 0, 2), 1'b0, '0},
      '{seg(0, 1, 1, 15, 2047), 1'b1, '0},
      '{seg(1, 0, 1, 15, 2047), 1'b1, '0},
      '{seg(1, 1, 1, 0, 0), 1'b0, '0},
      '{seg(1, 0, 0, 0, 9), 1'b0, '0},
      '{seg(1, 0, 0, 1, 1025), 1'b0, '0}
    };
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    foreach (rows[i]) send_segment(rows[i].req, rows[i].typed, rows[i].want);
    drain_results();
    for (int ph = 0; ph < PHASES; ph++) begin
      done_items = 0;
      while (done_items < PHASE_ITEMS) begin
        r = next_segment(counts);
        send_segment(r, 1'b0, '0);
        done_items += counts;
        if (ph != 0 || done_items > PHASE_ITEMS / 2) hold_sender(idle_pct[ph]);
      end
      drain_results();
    end
    repeat (30) @(posedge clk);
    if (exp_q.size() != 0) begin
      n_fail++;
      $display("%0t: %0d results never arrived", $time, exp_q.size());
    end
    $display("%0d requests: %0d marked in window, %0d re-acked, %0d past the store",
             n_sent, n_acc, n_reack, n_ovf);
    $display("%0d clears, %0d results with the transfer finished", n_clear, n_done);
    if (n_fail == 0) begin
      $display("tb_selective_repeat_window_tracker OK");
    end else begin
      $display("tb_selective_repeat_window_tracker NOT OK");
    end
    $finish;
  end

endmodule

@@ files.f @@
rtl/core/srw_pkg.sv
rtl/core/srw_front.sv
rtl/core/srw_queue.sv
rtl/core/srw_back.sv
rtl/core/selective_repeat_window_tracker.sv
verif/tb_selective_repeat_window_tracker.sv
